/* src/cimr_pkg.sv */
package cimr_pkg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  reg_offset;
        logic [7:0]  write_data;
        logic [7:0]  open_bus;
        logic        in_vblank;
        logic        hpos_late;
        logic        autojoy_busy;
        logic        raise_nmi;
        logic        raise_irq;
        logic [1:0]  joy_port;
        logic [15:0] joy_word;
    } t_in_item;

    typedef struct packed {
        logic [7:0] read_data;
        logic       irq_release;
        logic       nmi_enable;
        logic       h_irq_enable;
        logic       v_irq_enable;
        logic       autojoy_enable;
        logic [8:0] h_timer;
        logic [8:0] v_timer;
        logic       fast_rom;
        logic       ppu_latch_pulse;
        logic [7:0] dma_start_mask;
        logic [7:0] hdma_start_mask;
    } t_out_item;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_JOY   = 2'd2;
    localparam logic [1:0] OP_RAISE = 2'd3;

    localparam logic [4:0] R_NMITIMEN = 5'h00;
    localparam logic [4:0] R_WRIO     = 5'h01;
    localparam logic [4:0] R_WRMPYA   = 5'h02;
    localparam logic [4:0] R_WRMPYB   = 5'h03;
    localparam logic [4:0] R_WRDIVL   = 5'h04;
    localparam logic [4:0] R_WRDIVH   = 5'h05;
    localparam logic [4:0] R_WRDIVB   = 5'h06;
    localparam logic [4:0] R_HTIMEL   = 5'h07;
    localparam logic [4:0] R_HTIMEH   = 5'h08;
    localparam logic [4:0] R_VTIMEL   = 5'h09;
    localparam logic [4:0] R_VTIMEH   = 5'h0A;
    localparam logic [4:0] R_MDMAEN   = 5'h0B;
    localparam logic [4:0] R_HDMAEN   = 5'h0C;
    localparam logic [4:0] R_MEMSEL   = 5'h0D;
    localparam logic [4:0] R_RDNMI    = 5'h10;
    localparam logic [4:0] R_TIMEUP   = 5'h11;
    localparam logic [4:0] R_HVBJOY   = 5'h12;
    localparam logic [4:0] R_RDIO     = 5'h13;
    localparam logic [4:0] R_RDDIVL   = 5'h14;
    localparam logic [4:0] R_RDDIVH   = 5'h15;
    localparam logic [4:0] R_RDMPYL   = 5'h16;
    localparam logic [4:0] R_RDMPYH   = 5'h17;
    localparam logic [4:0] R_JOY1L    = 5'h18;
    localparam logic [4:0] R_JOY4H    = 5'h1F;

    typedef enum logic [2:0] {
        K_READ  = 3'd0,
        K_WRITE = 3'd1,
        K_DIV   = 3'd2,
        K_JOY   = 3'd3,
        K_RAISE = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  off;
        logic [7:0]  wd;
        logic [7:0]  ob;
        logic        vblank;
        logic        hlate;
        logic        ajbusy;
        logic        rnmi;
        logic        rirq;
        logic [1:0]  jport;
        logic [15:0] jword;
    } t_cmd;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam int DIV_CYCLES = 8;
    localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

    localparam logic [7:0]  RST_MCAND = 8'hFF;
    localparam logic [15:0] RST_POR   = 16'hFE01;
    localparam logic [15:0] RST_DVD   = 16'hFFFF;
    localparam logic [15:0] RST_QUOT  = 16'h0101;
    localparam logic [8:0]  RST_TIMER = 9'h1FF;
    localparam logic [15:0] DIV0_QUOT = 16'hFFFF;
    localparam logic [3:0]  RDNMI_LO  = 4'h2;

endpackage

/* src/cpu_io_math_irq_registers.sv */
// channel   direction  handshake                       payload
// in        input      i_in_valid / o_in_stall         i_in_data  (t_in_item)
// out       output     o_out_valid / i_out_stall       o_out_data (t_out_item)
//
// One result per transfer in, in order; each item passes the input register, the
// queue and the output register. A divide by a non-zero byte holds the back end
// in its divide state, two quotient bits per cycle, and no new item is popped.
// Reset is synchronous and active low; control and result state is loaded at once, data-path registers are not reset.
// A two-deep queue sits between the input register and the back end, so a
// stalled output does not stall input until the queue fills.
module cpu_io_math_irq_registers
    import cimr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_head;
    logic q_pop;

    cimr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (push),
        .o_push_cmd (push_cmd),
        .i_q_full   (q_full)
    );

    cimr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_push_cmd (push_cmd),
        .o_full     (q_full),
        .o_valid    (q_valid),
        .o_head     (q_head),
        .i_pop      (q_pop)
    );

    cimr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_head),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

/* src/cimr_front.sv */
module cimr_front
    import cimr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    output logic     o_push,
    output t_cmd     o_push_cmd,
    input  logic     i_q_full
);

    logic r_vld;
    t_cmd r_cmd;
    t_cmd n_cmd;
    logic accept;

    assign o_in_stall = r_vld && i_q_full;
    assign accept     = i_in_valid && !o_in_stall;
    assign o_push     = r_vld && !i_q_full;
    assign o_push_cmd = r_cmd;

    always_comb begin
        case (i_in_data.opcode)
            OP_READ:  n_cmd.kind = K_READ;
            OP_WRITE: n_cmd.kind = (i_in_data.reg_offset == R_WRDIVB) ? K_DIV : K_WRITE;
            OP_JOY:   n_cmd.kind = K_JOY;
            default:  n_cmd.kind = K_RAISE;
        endcase
        n_cmd.off    = i_in_data.reg_offset;
        n_cmd.wd     = i_in_data.write_data;
        n_cmd.ob     = i_in_data.open_bus;
        n_cmd.vblank = i_in_data.in_vblank;
        n_cmd.hlate  = i_in_data.hpos_late;
        n_cmd.ajbusy = i_in_data.autojoy_busy;
        n_cmd.rnmi   = i_in_data.raise_nmi;
        n_cmd.rirq   = i_in_data.raise_irq;
        n_cmd.jport  = i_in_data.joy_port;
        n_cmd.jword  = i_in_data.joy_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_push) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

/* src/cimr_queue.sv */
module cimr_queue
    import cimr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_cmd;
        end
    end

endmodule

/* src/cimr_back.sv */
module cimr_back
    import cimr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_cmd      i_q_cmd,
    output logic      o_q_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    typedef enum logic [1:0] {
        S_EXEC = 2'b01,
        S_DIV  = 2'b10
    } t_back_state;

    t_back_state r_state, n_state;
    logic [7:0]  r_mcand, n_mcand;
    logic [15:0] r_por, n_por;
    logic [15:0] r_dvd, n_dvd;
    logic [15:0] r_quot, n_quot;
    logic [8:0]  r_htm, n_htm;
    logic [8:0]  r_vtm, n_vtm;
    logic [3:0]  r_en, n_en;
    logic        r_nmi, n_nmi;
    logic        r_irq, n_irq;
    logic        r_latch, n_latch;
    logic        r_fast, n_fast;
    logic [15:0] r_joy [4];
    logic        joy_we;

    logic [15:0]          r_dq, n_dq;
    logic [7:0]           r_rem, n_rem;
    logic [7:0]           r_dvs, n_dvs;
    logic [DIV_CNT_W-1:0] r_dcnt, n_dcnt;
    logic [8:0]           s1, s2;

    logic      r_out_vld;
    t_out_item r_out, n_out;
    logic      out_free;
    logic [15:0] jw;

    function automatic logic [8:0] div_step(input logic [7:0] rem, input logic nb,
                                            input logic [7:0] d);
        logic [8:0] t;
        t = {rem, nb};
        if (t >= {1'b0, d}) begin
            return {8'(t - {1'b0, d}), 1'b1};
        end
        return {t[7:0], 1'b0};
    endfunction

    assign out_free    = !r_out_vld || !i_out_stall;
    assign o_q_pop     = (r_state == S_EXEC) && i_q_valid && out_free;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;
    assign joy_we      = o_q_pop && (i_q_cmd.kind == K_JOY);
    assign jw          = r_joy[i_q_cmd.off[2:1]];

    always_comb begin
        n_state = r_state;
        n_mcand = r_mcand;
        n_por   = r_por;
        n_dvd   = r_dvd;
        n_quot  = r_quot;
        n_htm   = r_htm;
        n_vtm   = r_vtm;
        n_en    = r_en;
        n_nmi   = r_nmi;
        n_irq   = r_irq;
        n_latch = r_latch;
        n_fast  = r_fast;
        n_dq    = r_dq;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_dcnt  = r_dcnt;
        s1      = div_step(r_rem, r_dq[15], r_dvs);
        s2      = div_step(s1[8:1], r_dq[14], r_dvs);
        n_out   = '0;

        case (r_state)
            S_EXEC: begin
                if (o_q_pop) begin
                    case (i_q_cmd.kind)
                        K_READ: begin
                            case (i_q_cmd.off)
                                R_RDNMI: begin
                                    n_out.read_data = {r_nmi, i_q_cmd.ob[6:4], RDNMI_LO};
                                    n_nmi = 1'b0;
                                end
                                R_TIMEUP: begin
                                    n_out.read_data   = {r_irq, i_q_cmd.ob[6:0]};
                                    n_irq             = 1'b0;
                                    n_out.irq_release = 1'b1;
                                end
                                R_HVBJOY: n_out.read_data = {i_q_cmd.vblank, i_q_cmd.hlate,
                                                             i_q_cmd.ob[5:1], i_q_cmd.ajbusy};
                                R_RDIO:   n_out.read_data = {r_latch, 7'h00};
                                R_RDDIVL: n_out.read_data = r_quot[7:0];
                                R_RDDIVH: n_out.read_data = r_quot[15:8];
                                R_RDMPYL: n_out.read_data = r_por[7:0];
                                R_RDMPYH: n_out.read_data = r_por[15:8];
                                default: begin
                                    if (i_q_cmd.off inside {[R_JOY1L:R_JOY4H]}) begin
                                        n_out.read_data = i_q_cmd.off[0] ? jw[15:8] : jw[7:0];
                                    end else begin
                                        n_out.read_data = i_q_cmd.ob;
                                    end
                                end
                            endcase
                        end
                        K_WRITE: begin
                            case (i_q_cmd.off)
                                R_NMITIMEN: begin
                                    n_en = {i_q_cmd.wd[7], i_q_cmd.wd[5], i_q_cmd.wd[4],
                                            i_q_cmd.wd[0]};
                                    if (n_en[2:1] == 2'b00) begin
                                        n_irq             = 1'b0;
                                        n_out.irq_release = 1'b1;
                                    end
                                end
                                R_WRIO: begin
                                    n_out.ppu_latch_pulse = r_latch && !i_q_cmd.wd[7];
                                    n_latch               = i_q_cmd.wd[7];
                                end
                                R_WRMPYA: n_mcand = i_q_cmd.wd;
                                R_WRMPYB: n_por   = {8'h00, r_mcand} * {8'h00, i_q_cmd.wd};
                                R_WRDIVL: n_dvd   = {r_dvd[15:8], i_q_cmd.wd};
                                R_WRDIVH: n_dvd   = {i_q_cmd.wd, r_dvd[7:0]};
                                R_HTIMEL: n_htm   = {r_htm[8], i_q_cmd.wd};
                                R_HTIMEH: n_htm   = {i_q_cmd.wd[0], r_htm[7:0]};
                                R_VTIMEL: n_vtm   = {r_vtm[8], i_q_cmd.wd};
                                R_VTIMEH: n_vtm   = {i_q_cmd.wd[0], r_vtm[7:0]};
                                R_MDMAEN: n_out.dma_start_mask  = i_q_cmd.wd;
                                R_HDMAEN: n_out.hdma_start_mask = i_q_cmd.wd;
                                R_MEMSEL: n_fast = i_q_cmd.wd[0];
                                default: ;
                            endcase
                        end
                        K_DIV: begin
                            if (i_q_cmd.wd == 8'h00) begin
                                n_quot = DIV0_QUOT;
                                n_por  = r_dvd;
                            end else begin
                                n_dq    = r_dvd;
                                n_rem   = '0;
                                n_dvs   = i_q_cmd.wd;
                                n_dcnt  = '0;
                                n_state = S_DIV;
                            end
                        end
                        K_RAISE: begin
                            n_nmi = r_nmi || i_q_cmd.rnmi;
                            n_irq = r_irq || i_q_cmd.rirq;
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                n_dq   = {r_dq[13:0], s1[0], s2[0]};
                n_rem  = s2[8:1];
                n_dcnt = r_dcnt + 1'b1;
                if (r_dcnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
                    n_quot  = n_dq;
                    n_por   = {8'h00, n_rem};
                    n_state = S_EXEC;
                end
            end
            default: n_state = S_EXEC;
        endcase

        n_out.nmi_enable     = n_en[3];
        n_out.h_irq_enable   = n_en[1];
        n_out.v_irq_enable   = n_en[2];
        n_out.autojoy_enable = n_en[0];
        n_out.h_timer        = n_htm;
        n_out.v_timer        = n_vtm;
        n_out.fast_rom       = n_fast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_EXEC;
            r_mcand   <= RST_MCAND;
            r_por     <= RST_POR;
            r_dvd     <= RST_DVD;
            r_quot    <= RST_QUOT;
            r_htm     <= RST_TIMER;
            r_vtm     <= RST_TIMER;
            r_en      <= '0;
            r_nmi     <= 1'b0;
            r_irq     <= 1'b0;
            r_latch   <= 1'b0;
            r_fast    <= 1'b0;
            r_out_vld <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_joy[i] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_mcand   <= n_mcand;
            r_por     <= n_por;
            r_dvd     <= n_dvd;
            r_quot    <= n_quot;
            r_htm     <= n_htm;
            r_vtm     <= n_vtm;
            r_en      <= n_en;
            r_nmi     <= n_nmi;
            r_irq     <= n_irq;
            r_latch   <= n_latch;
            r_fast    <= n_fast;
            r_out_vld <= o_q_pop || (r_out_vld && i_out_stall);
            if (joy_we) begin
                r_joy[i_q_cmd.jport] <= i_q_cmd.jword;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dq   <= n_dq;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_dcnt <= n_dcnt;
        if (o_q_pop) begin
            r_out <= n_out;
        end
    end

endmodule

/* src/cimr_checker.sv */
module cimr_checker
    import cimr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    logic [2:0] r_pend;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (in_xfer && !out_xfer) begin
            r_pend <= r_pend + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            r_pend <= r_pend - 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_pend != 3'd0)
        else $error("result with no transfer outstanding");

    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd4)
        else $error("more transfers held than storage allows");

    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend == 3'd0 |-> !o_in_stall)
        else $error("input stalled while empty");

    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |-> !$isunknown(i_in_data.opcode))
        else $error("unknown opcode on transfer");

endmodule

bind cpu_io_math_irq_registers cimr_checker u_cimr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
